[hw/rtl/rmsb_pkg.sv]
// ----------------------------------------------------------------------------
// rmsb_pkg: shared types and codes for the radio MAC sequencer
// Event and result records, operation, radio state, mode, command and receive
// codes, queue sizing and the ring index helper.
// ----------------------------------------------------------------------------
package rmsb_pkg;

    localparam int QUEUE_SLOTS  = 4;
    localparam int MAX_MESSAGE  = 64;
    localparam int QPTR_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int MIN_FRAME    = 7;
    localparam int STATUS_BYTES = 4;
    localparam int MAX_STATUS   = MAX_MESSAGE + 3;

    localparam logic [2:0] OP_IRQ   = 3'd0;
    localparam logic [2:0] OP_SEND  = 3'd1;
    localparam logic [2:0] OP_POLL  = 3'd2;
    localparam logic [2:0] OP_SLEEP = 3'd3;
    localparam logic [2:0] OP_WAKE  = 3'd4;

    localparam logic [1:0] RS_OTHER = 2'd0;
    localparam logic [1:0] RS_IDLE  = 2'd1;
    localparam logic [1:0] RS_RX    = 2'd2;
    localparam logic [1:0] RS_TX    = 2'd3;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_RXIDLE = 3'd1;
    localparam logic [2:0] MODE_RXDATA = 3'd2;
    localparam logic [2:0] MODE_TXHDR  = 3'd3;
    localparam logic [2:0] MODE_TXDATA = 3'd4;
    localparam logic [2:0] MODE_ASLEEP = 3'd5;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_POWER   = 2'd2;
    localparam logic [1:0] CMD_IDLE    = 2'd3;

    localparam logic [2:0] RX_NONE    = 3'd0;
    localparam logic [2:0] RX_OK      = 3'd1;
    localparam logic [2:0] RX_BADSIZE = 3'd2;
    localparam logic [2:0] RX_NOBUF   = 3'd3;
    localparam logic [2:0] RX_BADCRC  = 3'd4;

    typedef struct packed {
        logic [7:0] packet_handle;
        logic       buffer_free;
        logic       crc_good;
        logic [7:0] rx_fifo_status;
        logic       channel_clear;
        logic [1:0] radio_state;
        logic [2:0] operation;
    } event_t;

    typedef struct packed {
        logic [2:0] mode_now;
        logic [1:0] radio_command;
        logic [6:0] rx_payload_length;
        logic [2:0] rx_result;
        logic       tx_dropped;
        logic [7:0] tx_handle;
        logic       tx_start;
    } result_t;

    typedef logic [QPTR_W-1:0] qptr_t;

    function automatic qptr_t next_slot(qptr_t i);
        qptr_t n;
        if (i == QPTR_W'(QUEUE_SLOTS - 1))
            n = '0;
        else
            n = i + QPTR_W'(1);
        return n;
    endfunction

endpackage

[hw/rtl/radio_mac_sequencer_with_backoff_core.sv]
// ----------------------------------------------------------------------------
// radio_mac_sequencer_with_backoff_core: packet radio MAC control
// Channel     | Direction | Handshake                 | Payload
// s_axis      | in        | s_tvalid / s_tready       | s_tdata, s_tuser (event)
// m_axis      | out       | m_tvalid / m_tready       | m_tdata (one result per event)
// cfg         | in        | cfg_we                    | cfg_wdata (node_id)
//
// One event enters per cycle while the result side does not stall; the event
// waits in the input register, then its result in the result register.
// The sequencer updates mode, queue and backoff in the cycle the event moves
// from the input register to the result register.
// A stalled result stops that move; the input register still takes one more
// event while the result waits, but only when it is empty.
// Reset clears mode, queue pointers, backoff and node_id; queue slots are not
// cleared.
// ----------------------------------------------------------------------------
module radio_mac_sequencer_with_backoff_core
    import rmsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // node_id
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: radio_state[1:0], channel_clear, rx_fifo_status[7:0],
    // crc_good, buffer_free, packet_handle[7:0], zero pad
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,     // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: tx_start, tx_handle[7:0], tx_dropped, rx_result[2:0],
    // rx_payload_length[6:0], radio_command[1:0], mode_now[2:0], zero pad
    output logic [31:0] m_tdata
);

    logic    evt_valid;
    event_t  evt;
    result_t result;
    logic    out_free;
    logic    advance;

    assign advance = evt_valid && out_free;

    rmsb_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    rmsb_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .evt       (evt),
        .result    (result)
    );

    rmsb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_ready_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !out_free |-> !s_tready)
        else $error("input taken while stage is blocked");

    a_start_excludes_drop: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(result.tx_start && result.tx_dropped))
        else $error("start and drop in one result");

    a_start_enters_txhdr: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.tx_start |-> result.mode_now == MODE_TXHDR)
        else $error("transmit started outside tx header");

    a_rx_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.rx_result != RX_NONE
        |-> result.radio_command == CMD_RESTART && result.mode_now == MODE_RXIDLE)
        else $error("frame judged without receiver restart");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced event produced no result");
`endif

endmodule

[hw/rtl/rmsb_in_stage.sv]
// ----------------------------------------------------------------------------
// rmsb_in_stage: event input register
// Captures one event transaction and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module rmsb_in_stage
    import rmsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        advance,
    output logic        evt_valid,
    output event_t      evt
);

    logic   valid_reg;
    logic   valid_next;
    event_t evt_reg;

    assign s_tready  = !valid_reg || advance;
    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
            valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // bits 23:21 of tdata are padding
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            evt_reg.operation      <= s_tuser;
            evt_reg.radio_state    <= s_tdata[1:0];
            evt_reg.channel_clear  <= s_tdata[2];
            evt_reg.rx_fifo_status <= s_tdata[10:3];
            evt_reg.crc_good       <= s_tdata[11];
            evt_reg.buffer_free    <= s_tdata[12];
            evt_reg.packet_handle  <= s_tdata[20:13];
        end
    end

endmodule

[hw/rtl/rmsb_sequencer.sv]
// ----------------------------------------------------------------------------
// rmsb_sequencer: transceiver mode, handle queue and backoff
// Decides the result of one event and updates state when it advances.
// ----------------------------------------------------------------------------
module rmsb_sequencer
    import rmsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       advance,
    input  event_t     evt,
    output result_t    result
);

    logic [7:0] node_id_reg;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    qptr_t      head_reg;
    qptr_t      head_next;
    qptr_t      tail_reg;
    qptr_t      tail_next;
    logic [3:0] backoff_reg;
    logic [3:0] backoff_next;
    logic [7:0] pending_reg [QUEUE_SLOTS];
    logic       push;
    logic       queue_empty;
    logic       bad_size;
    result_t    res;

    assign queue_empty = (head_reg == tail_reg);
    assign bad_size = (evt.rx_fifo_status[6:0] < 7'(MIN_FRAME))
                   || evt.rx_fifo_status[7]
                   || (evt.rx_fifo_status > 8'(MAX_STATUS));
    assign result = res;

    always_comb
    begin
        mode_next    = mode_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        backoff_next = backoff_reg;
        push         = 1'b0;
        res          = '0;
        case (evt.operation)
            OP_IRQ:
            begin
                if (mode_reg == MODE_RXIDLE && evt.radio_state == RS_RX)
                    mode_next = MODE_RXDATA;
                else if (mode_reg == MODE_TXHDR && evt.radio_state == RS_TX)
                    mode_next = MODE_TXDATA;
                else
                begin
                    if (mode_reg == MODE_RXDATA && evt.radio_state == RS_IDLE)
                    begin
                        if (bad_size)
                            res.rx_result = RX_BADSIZE;
                        else if (!evt.buffer_free)
                            res.rx_result = RX_NOBUF;
                        else if (!evt.crc_good)
                            res.rx_result = RX_BADCRC;
                        else
                        begin
                            res.rx_result = RX_OK;
                            res.rx_payload_length =
                                7'(evt.rx_fifo_status - 8'(STATUS_BYTES));
                        end
                    end
                    res.radio_command = CMD_RESTART;
                    mode_next = MODE_RXIDLE;
                end
            end
            OP_SEND:
            begin
                if (queue_empty && mode_reg == MODE_RXIDLE && evt.channel_clear)
                begin
                    res.tx_start  = 1'b1;
                    res.tx_handle = evt.packet_handle;
                    mode_next     = MODE_TXHDR;
                end
                else if (next_slot(head_reg) == tail_reg)
                begin
                    res.tx_dropped = 1'b1;
                    res.tx_handle  = evt.packet_handle;
                end
                else
                begin
                    push      = 1'b1;
                    head_next = next_slot(head_reg);
                end
            end
            OP_POLL:
            begin
                if (mode_reg == MODE_RXIDLE && !queue_empty)
                begin
                    if (backoff_reg != 4'd0)
                        backoff_next = backoff_reg - 4'd1;
                    else if (!evt.channel_clear)
                        backoff_next = node_id_reg[7:4];
                    else
                    begin
                        res.tx_start  = 1'b1;
                        res.tx_handle = pending_reg[tail_reg];
                        tail_next     = next_slot(tail_reg);
                        mode_next     = MODE_TXHDR;
                    end
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    res.radio_command = CMD_RESTART;
                    mode_next = MODE_RXIDLE;
                end
            end
            OP_SLEEP:
            begin
                res.radio_command = CMD_POWER;
                mode_next = MODE_ASLEEP;
            end
            OP_WAKE:
            begin
                res.radio_command = CMD_IDLE;
                mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
        res.mode_now = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= 8'd0;
            mode_reg    <= MODE_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            backoff_reg <= 4'd0;
        end
        else
        begin
            if (cfg_we)
                node_id_reg <= cfg_wdata;
            if (advance)
            begin
                mode_reg    <= mode_next;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                backoff_reg <= backoff_next;
            end
        end
    end

    // queue slots hold no reset; only written slots are ever read
    always_ff @(posedge clk)
    begin
        if (advance && push)
            pending_reg[head_reg] <= evt.packet_handle;
    end

endmodule

[hw/rtl/rmsb_out_stage.sv]
// ----------------------------------------------------------------------------
// rmsb_out_stage: result output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module rmsb_out_stage
    import rmsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

endmodule

[sim/radio_mac_sequencer_with_backoff_checker.sv]
// ----------------------------------------------------------------------------
// radio_mac_sequencer_with_backoff_checker: result checker for the MAC sequencer
// Watches the event, result and node_id channels, runs its own copy of the
// sequencer (mode, handle ring, backoff) on every event transaction, and
// compares each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module radio_mac_sequencer_with_backoff_checker
    import rmsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          failures,
    output int          outstanding,
    output int          results_seen
);

    localparam int RES_W = $bits(result_t);

    // shadow copy of the sequencer
    logic [2:0] cur_mode;
    logic [7:0] handle_ring [QUEUE_SLOTS];
    qptr_t      ring_wr;
    qptr_t      ring_rd;
    logic [3:0] backoff;
    logic [7:0] node_addr;

    result_t    awaited_results [$];
    result_t    want;
    result_t    got;
    int         fail_cnt = 0;
    int         result_cnt = 0;

    assign failures     = fail_cnt;
    assign results_seen = result_cnt;

    function automatic qptr_t ring_advance(input qptr_t p);
        return (p == qptr_t'(QUEUE_SLOTS - 1)) ? qptr_t'(0) : qptr_t'(p + 1);
    endfunction

    function automatic result_t sequence_event(input event_t ev);
        result_t r;
        qptr_t   after;
        r = '0;
        case (ev.operation)
            OP_IRQ:
            begin
                if (cur_mode == MODE_RXIDLE && ev.radio_state == RS_RX)
                begin
                    cur_mode = MODE_RXDATA;
                end
                else if (cur_mode == MODE_TXHDR && ev.radio_state == RS_TX)
                begin
                    cur_mode = MODE_TXDATA;
                end
                else
                begin
                    // judge the frame only when reception has just finished
                    if (cur_mode == MODE_RXDATA && ev.radio_state == RS_IDLE)
                    begin
                        if (ev.rx_fifo_status[6:0] < MIN_FRAME || ev.rx_fifo_status[7]
                            || ev.rx_fifo_status > MAX_STATUS)
                            r.rx_result = RX_BADSIZE;
                        else if (!ev.buffer_free)
                            r.rx_result = RX_NOBUF;
                        else if (!ev.crc_good)
                            r.rx_result = RX_BADCRC;
                        else
                        begin
                            r.rx_result         = RX_OK;
                            r.rx_payload_length = 7'(ev.rx_fifo_status - STATUS_BYTES);
                        end
                    end
                    r.radio_command = CMD_RESTART;
                    cur_mode        = MODE_RXIDLE;
                end
            end
            OP_SEND:
            begin
                if (ring_wr == ring_rd && cur_mode == MODE_RXIDLE && ev.channel_clear)
                begin
                    r.tx_start  = 1'b1;
                    r.tx_handle = ev.packet_handle;
                    cur_mode    = MODE_TXHDR;
                end
                else
                begin
                    after = ring_advance(ring_wr);
                    if (after == ring_rd)
                    begin
                        r.tx_dropped = 1'b1;
                        r.tx_handle  = ev.packet_handle;
                    end
                    else
                    begin
                        handle_ring[ring_wr] = ev.packet_handle;
                        ring_wr              = after;
                    end
                end
            end
            OP_POLL:
            begin
                if (cur_mode == MODE_RXIDLE && ring_wr != ring_rd)
                begin
                    if (backoff != 4'd0)
                        backoff = backoff - 4'd1;
                    else if (!ev.channel_clear)
                        backoff = node_addr[7:4];
                    else
                    begin
                        r.tx_start  = 1'b1;
                        r.tx_handle = handle_ring[ring_rd];
                        ring_rd     = ring_advance(ring_rd);
                        cur_mode    = MODE_TXHDR;
                    end
                end
                else if (cur_mode == MODE_IDLE)
                begin
                    r.radio_command = CMD_RESTART;
                    cur_mode        = MODE_RXIDLE;
                end
            end
            OP_SLEEP:
            begin
                r.radio_command = CMD_POWER;
                cur_mode        = MODE_ASLEEP;
            end
            OP_WAKE:
            begin
                r.radio_command = CMD_IDLE;
                cur_mode        = MODE_IDLE;
            end
            default: ;
        endcase
        r.mode_now = cur_mode;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode  = MODE_IDLE;
            ring_wr   = '0;
            ring_rd   = '0;
            backoff   = '0;
            node_addr = '0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // retire the result transaction first; its event was taken at an earlier edge
            if (m_tvalid && m_tready)
            begin
                result_cnt++;
                got = result_t'(m_tdata[RES_W-1:0]);
                if (awaited_results.size() == 0)
                begin
                    $error("result with no pending event: m_tdata %h", m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("tx_start", want.tx_start, got.tx_start);
                    compare_field("tx_handle", want.tx_handle, got.tx_handle);
                    compare_field("tx_dropped", want.tx_dropped, got.tx_dropped);
                    compare_field("rx_result", want.rx_result, got.rx_result);
                    compare_field("rx_payload_length", want.rx_payload_length,
                                  got.rx_payload_length);
                    compare_field("radio_command", want.radio_command, got.radio_command);
                    compare_field("mode_now", want.mode_now, got.mode_now);
                    compare_field("pad", 0, m_tdata[31:RES_W]);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(sequence_event(event_t'({s_tdata[20:0], s_tuser})));
            if (cfg_we)
                node_addr = cfg_wdata;
            outstanding <= awaited_results.size();
        end
    end

endmodule

[sim/radio_mac_sequencer_with_backoff_core_tb.sv]
// ----------------------------------------------------------------------------
// radio_mac_sequencer_with_backoff_core_tb: top of the MAC sequencer bench
// Drives a directed event sequence, then randomized receive, transmit, queue,
// sleep and noise sequences under several node_id settings, with random idle
// bursts on both streams. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module radio_mac_sequencer_with_backoff_core_tb;
    import rmsb_pkg::*;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    int fail_count;
    int in_flight;
    int results_seen;
    int sent_count    = 0;
    int ignored_count = 0;
    int config_count  = 0;
    int stall_left    = 0;
    bit calm          = 1'b0;

    radio_mac_sequencer_with_backoff_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    radio_mac_sequencer_with_backoff_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .failures     (fail_count),
        .outstanding  (in_flight),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: random stall bursts on m_tready
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // receive status byte: boundaries, legal frame sizes, or anything
    function automatic logic [7:0] frame_status();
        logic [7:0] corners [11] = '{8'd0, 8'd6, 8'd7, 8'd8, 8'd66, 8'd67, 8'd68,
                                    8'h7F, 8'h80, 8'h87, 8'hFF};
        case ($urandom_range(0, 3))
            0:       return rand_byte();
            1:       return corners[$urandom_range(0, 10)];
            default: return 8'($urandom_range(MIN_FRAME, MAX_STATUS));
        endcase
    endfunction

    task automatic send_event(input logic [2:0] op, input logic [1:0] rs, input logic clr,
                              input logic [7:0] fifo, input logic crc, input logic bfree,
                              input logic [7:0] hdl);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, hdl, bfree, crc, fifo, clr, rs};
        // hold until the transaction completes
        do @(posedge clk); while (!s_tready);
        sent_count++;
        if (op > OP_WAKE)
            ignored_count++;
    endtask

    task automatic send_simple(input logic [2:0] op, input logic [1:0] rs, input logic clr);
        send_event(op, rs, clr, rand_byte(), rand_bit(), rand_bit(), rand_byte());
    endtask

    task automatic directed_frame(input logic [7:0] fifo, input logic crc, input logic bfree);
        send_event(OP_IRQ, RS_RX, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_IRQ, RS_IDLE, 1'b0, fifo, crc, bfree, 8'h00);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] addr);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        config_count++;
    endtask

    task automatic run_random(input int target);
        int stop_at;
        int n;
        stop_at = sent_count - ignored_count + target;
        while (sent_count - ignored_count < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // complete reception
                    send_simple(OP_IRQ, RS_OTHER, rand_bit());
                    send_simple(OP_IRQ, RS_RX, rand_bit());
                    n = $urandom_range(0, 2);
                    repeat (n) send_simple(OP_POLL, 2'($urandom_range(0, 3)), rand_bit());
                    send_event(OP_IRQ, RS_IDLE, rand_bit(), frame_status(),
                               $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                               rand_byte());
                end
                3, 4:
                begin
                    // direct transmit
                    send_simple(OP_IRQ, RS_OTHER, rand_bit());
                    send_simple(OP_SEND, 2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0);
                    send_simple(OP_IRQ, RS_TX, rand_bit());
                    send_simple(OP_IRQ, rand_bit() ? RS_IDLE : RS_OTHER, rand_bit());
                end
                5, 6:
                begin
                    // fill the ring, then drain it with backoff polling
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_simple(OP_SEND, 2'($urandom_range(0, 3)),
                                    $urandom_range(0, 2) == 0);
                    n = $urandom_range(1, 20);
                    repeat (n)
                    begin
                        send_simple(OP_POLL, 2'($urandom_range(0, 3)),
                                    $urandom_range(0, 3) != 0);
                        if (rand_bit())
                        begin
                            if (rand_bit())
                                send_simple(OP_IRQ, RS_TX, rand_bit());
                            send_simple(OP_IRQ, RS_OTHER, rand_bit());
                        end
                    end
                end
                7:
                begin
                    send_simple(OP_SLEEP, 2'($urandom_range(0, 3)), rand_bit());
                    n = $urandom_range(0, 2);
                    repeat (n)
                        send_simple(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                    rand_bit());
                    send_simple(OP_WAKE, 2'($urandom_range(0, 3)), rand_bit());
                    send_simple(OP_POLL, 2'($urandom_range(0, 3)), rand_bit());
                end
                default:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_simple(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                    rand_bit());
                end
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] node_plan [6];
        node_plan = '{8'h00, 8'hFF, 8'hF0, 8'h0F, rand_byte(), 8'h20};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: frames, queue, drop, backoff, sleep, wake
        configure(8'h10);
        send_event(OP_POLL, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_SEND, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'hFF);
        send_event(OP_IRQ, RS_TX, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_IRQ, RS_IDLE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        directed_frame(8'd7, 1'b1, 1'b1);
        directed_frame(8'd67, 1'b1, 1'b1);
        directed_frame(8'd68, 1'b1, 1'b1);
        directed_frame(8'h87, 1'b1, 1'b1);
        directed_frame(8'h20, 1'b1, 1'b0);
        directed_frame(8'h20, 1'b0, 1'b1);
        send_event(OP_SEND, RS_OTHER, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_SEND, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'hAA);
        send_event(OP_SEND, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'h55);
        send_event(OP_SEND, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'h12);
        send_event(OP_POLL, RS_OTHER, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_POLL, RS_OTHER, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_POLL, RS_OTHER, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_SLEEP, RS_OTHER, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(OP_WAKE, RS_OTHER, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_event(3'd7, 2'b11, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF);

        for (int ph = 0; ph < 6; ph++)
        begin
            configure(node_plan[ph]);
            calm <= (ph == 2 || ph == 5);
            run_random(100);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d events (%0d unused opcodes), %0d results, %0d node_id writes",
                 sent_count, ignored_count, results_seen, config_count);
        if (fail_count == 0 && in_flight == 0)
            $display("radio_mac_sequencer_with_backoff_core_tb: PASS");
        else
            $display("radio_mac_sequencer_with_backoff_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("radio_mac_sequencer_with_backoff_core_tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rmsb_pkg.sv
hw/rtl/rmsb_in_stage.sv
hw/rtl/rmsb_sequencer.sv
hw/rtl/rmsb_out_stage.sv
hw/rtl/radio_mac_sequencer_with_backoff_core.sv
sim/radio_mac_sequencer_with_backoff_checker.sv
sim/radio_mac_sequencer_with_backoff_core_tb.sv
